// File: sv/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg - descriptor queue shared types
// operation codes, result kinds and the beat structs passed between parts
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 16;
  localparam int PIDX_W  = 4;
  localparam int WRAP_W  = 32;
  localparam int DRAIN_W = 5;
  localparam int BL_W    = 40;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVICE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_DROPPED  = 3'd1,
    KIND_DELIVER  = 3'd2,
    KIND_OVERRUN  = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    logic [PIDX_W-1:0]   pidx;
    logic [WRAP_W-1:0]   pwrap;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    logic [DRAIN_W-1:0]  drained;
  } res_t;

endpackage
`default_nettype wire

// File: sv/dq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/dq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_front - input side of the descriptor queue
// takes input beats, decodes the operation and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module dq_front
  import dq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic [ADDR_W-1:0]  in_buffer_address,
  input  wire logic [LEN_W-1:0]   in_data_length,
  input  wire logic [PIDX_W-1:0]  in_producer_read_index,
  input  wire logic [WRAP_W-1:0]  in_producer_wrap_count,
  output logic                    item_valid,
  output item_t                   item,
  input  wire logic               item_pop
);

  item_t       entry_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       in_item;

  always_comb begin
    in_item.op    = in_operation ? OP_SERVICE : OP_ENQUEUE;
    in_item.addr  = in_buffer_address;
    in_item.len   = in_data_length;
    in_item.pidx  = in_producer_read_index;
    in_item.pwrap = in_producer_wrap_count;
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (item_pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, item_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/dq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_back - execution side of the descriptor queue
// owns the descriptor ram, ring pointers, host position and backlog check
// ----------------------------------------------------------------------------
module dq_back
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       item_pop,
  input  wire logic  slot_free,
  output logic       res_valid,
  output res_t       res
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int HW = (PW > PIDX_W) ? PW : PIDX_W;
  localparam int NW = (CW > DRAIN_W) ? CW : DRAIN_W;
  localparam int RW = ADDR_W + LEN_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIFF   = 5'b00010,
    S_MULT   = 5'b00100,
    S_SUB    = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [HW-1:0]       hidx_r, hidx_nxt;
  logic [WRAP_W-1:0]   hwrap_r, hwrap_nxt;
  logic [PIDX_W-1:0]   pidx_r;
  logic [WRAP_W-1:0]   pwrap_r;
  logic [WRAP_W-1:0]   d_r;
  logic [BL_W-1:0]     prod_r;
  logic                neg_r;
  logic [BL_W-1:0]     backlog_r;

  logic                go;
  logic                ram_we, ram_re;
  logic [PW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_rdata;
  logic [PW:0]         tail_sum, drain_sum;
  logic [PW-1:0]       head_inc;
  logic [BL_W-1:0]     pos;
  logic [CW-1:0]       space;
  logic                overrun;
  logic [BL_W-1:0]     excess;
  logic [CW-1:0]       n_drain;
  logic [NW-1:0]       n_ext;
  logic [HW:0]         adv;

  dq_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item.addr, item.len}),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign go       = (state_r == S_IDLE) && item_valid && slot_free;
  assign item_pop = go;
  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);

  // tail slot: head + occupancy folded once into the ring
  always_comb begin
    tail_sum = (PW+1)'(head_r) + (PW+1)'(occ_r);
    if (tail_sum >= (PW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (PW+1)'(DEPTH);
    end
  end
  assign ram_waddr = tail_sum[PW-1:0];

  assign ram_we = go && (item.op == OP_ENQUEUE) && (occ_r != CW'(DEPTH));
  assign ram_re = go && (item.op == OP_SERVICE) && (occ_r != '0);

  // backlog arithmetic, one step per state
  assign pos = prod_r + BL_W'(pidx_r);

  assign space   = CW'(DEPTH) - occ_r;
  assign overrun = (backlog_r > BL_W'(space));
  assign excess  = backlog_r - BL_W'(space);
  assign n_drain = (excess < BL_W'(occ_r)) ? excess[CW-1:0] : occ_r;
  assign n_ext   = NW'(n_drain);

  always_comb begin
    drain_sum = (PW+1)'(head_r) + (PW+1)'(n_drain);
    if (drain_sum >= (PW+1)'(DEPTH)) begin
      drain_sum = drain_sum - (PW+1)'(DEPTH);
    end
  end

  // host index advance: a copied producer index may sit above the ring size
  always_comb begin
    adv = (HW+1)'(hidx_r) + (HW+1)'(1);
    for (int i = 0; i < 8; i++) begin
      if (adv >= (HW+1)'(DEPTH)) begin
        adv = adv - (HW+1)'(DEPTH);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    occ_nxt   = occ_r;
    hidx_nxt  = hidx_r;
    hwrap_nxt = hwrap_r;
    res_valid = 1'b0;
    res.kind    = KIND_ACCEPTED;
    res.addr    = '0;
    res.len     = '0;
    res.drained = '0;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          if (item.op == OP_ENQUEUE) begin
            res_valid = 1'b1;
            if (occ_r == CW'(DEPTH)) begin
              res.kind = KIND_DROPPED;
            end else begin
              res.kind = KIND_ACCEPTED;
              occ_nxt  = occ_r + CW'(1);
            end
          end else if (occ_r == '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end else begin
            head_nxt  = head_inc;
            occ_nxt   = occ_r - CW'(1);
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        state_nxt = S_MULT;
      end
      S_MULT: begin
        state_nxt = S_SUB;
      end
      S_SUB: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
        if (overrun) begin
          res.kind    = KIND_OVERRUN;
          res.drained = n_ext[DRAIN_W-1:0];
          head_nxt    = drain_sum[PW-1:0];
          occ_nxt     = occ_r - n_drain;
          hidx_nxt    = HW'(pidx_r);
          hwrap_nxt   = pwrap_r;
        end else begin
          res.kind = KIND_DELIVER;
          res.addr = ram_rdata[RW-1 -: ADDR_W];
          res.len  = ram_rdata[LEN_W-1:0];
          hidx_nxt = adv[HW-1:0];
          if (adv[HW-1:0] < hidx_r) begin
            hwrap_nxt = hwrap_r + WRAP_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath registers of the backlog chain
  always_ff @(posedge clk) begin
    if (ram_re) begin
      pidx_r  <= item.pidx;
      pwrap_r <= item.pwrap;
    end
    if (state_r == S_DIFF) begin
      d_r <= pwrap_r - hwrap_r;
    end
    if (state_r == S_MULT) begin
      neg_r <= d_r[WRAP_W-1];
      // d below 2^31 and DEPTH at most 256 keep the product under 2^39
      prod_r <= (d_r == '0 || d_r[WRAP_W-1]) ? '0 : BL_W'(d_r) * BL_W'(DEPTH);
    end
    if (state_r == S_SUB) begin
      if (neg_r || pos <= BL_W'(hidx_r)) begin
        backlog_r <= '0;
      end else begin
        backlog_r <= pos - BL_W'(hidx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
      hidx_r  <= '0;
      hwrap_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      hidx_r  <= hidx_nxt;
      hwrap_r <= hwrap_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above ring size");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= PW'(DEPTH - 1))
    else $error("head pointer outside ring");

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> slot_free)
    else $error("result raised while output slot is occupied");

  a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !item_pop)
    else $error("queue popped during a service computation");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> (occ_r == $past(occ_r) || occ_r == $past(occ_r) + CW'(1)
      || occ_r == $past(occ_r) - CW'(1)))
    else $error("occupancy moved by more than one outside a flush");

endmodule
`default_nettype wire

// File: sv/descriptor_queue_with_overrun_flush.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_queue_with_overrun_flush - descriptor fifo with overrun flush
// stores buffer descriptors, serves them to a consumer and flushes the
// backlog when the producer has run ahead of the free space
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | operation, address, length, prod. index/wraps
//  result   | out_valid/out_ready  | result kind, address, length, drained count
//
//  enqueue beats and services on an empty queue are answered from the idle state
//  a service that pops steps through ram read, wrap difference,
//  multiply by ring size, backlog subtract, overrun compare and update
//  a two-entry input queue takes beats until it is full while the back end works or
//  while a result waits in the output register
//  synchronous active-low reset clears pointers, occupancy and host position;
//  descriptor storage is not cleared, every slot is written before it is read
//
module descriptor_queue_with_overrun_flush
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_operation,
  input  wire logic [ADDR_W-1:0]  in_buffer_address,
  input  wire logic [LEN_W-1:0]   in_data_length,
  input  wire logic [PIDX_W-1:0]  in_producer_read_index,
  input  wire logic [WRAP_W-1:0]  in_producer_wrap_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_result_kind,
  output logic [ADDR_W-1:0]       out_address,
  output logic [LEN_W-1:0]        out_length,
  output logic [DRAIN_W-1:0]      out_drained_count
);

  item_t  item;
  logic   item_valid;
  logic   item_pop;
  logic   slot_free;
  logic   res_valid;
  res_t   res;
  logic   out_valid_r;
  res_t   out_r;

  // front: accept and decode input beats
  dq_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_buffer_address      (in_buffer_address),
    .in_data_length         (in_data_length),
    .in_producer_read_index (in_producer_read_index),
    .in_producer_wrap_count (in_producer_wrap_count),
    .item_valid             (item_valid),
    .item                   (item),
    .item_pop               (item_pop)
  );

  // back: ring storage, backlog check and host position
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register: free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_r.kind;
  assign out_address       = out_r.addr;
  assign out_length        = out_r.len;
  assign out_drained_count = out_r.drained;

endmodule
`default_nettype wire

// File: bench/tb_descriptor_queue_with_overrun_flush.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_descriptor_queue_with_overrun_flush - descriptor queue testbench
// drives enqueue and service beats through the valid/ready input channel,
// mirrors the fifo, host position and overrun flush in a local model, and
// checks every result beat in order against the model's prediction
// ----------------------------------------------------------------------------
module tb_descriptor_queue_with_overrun_flush;
  import dq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HOLD_CYCLES   = 150;   // long output hold-off for back-pressure
  localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 32;    // drain time after the last result
  localparam logic [63:0] BACKLOG_CAP = (64'd1 << BL_W) - 64'd1;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel, all known from time zero
  logic                in_valid               = 1'b0;
  logic                in_ready;
  logic                in_operation           = 1'b0;
  logic [ADDR_W-1:0]   in_buffer_address      = '0;
  logic [LEN_W-1:0]    in_data_length         = '0;
  logic [PIDX_W-1:0]   in_producer_read_index = '0;
  logic [WRAP_W-1:0]   in_producer_wrap_count = '0;

  // result channel
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_result_kind;
  logic [ADDR_W-1:0]   out_address;
  logic [LEN_W-1:0]    out_length;
  logic [DRAIN_W-1:0]  out_drained_count;

  // mirror of the queue and of the host ring position
  logic [ADDR_W-1:0]   mirror_addr [DEPTH];
  logic [LEN_W-1:0]    mirror_len  [DEPTH];
  logic [PIDX_W-1:0]   mirror_head  = '0;
  int unsigned         mirror_count = 0;
  logic [PIDX_W-1:0]   host_pos     = '0;
  logic [WRAP_W-1:0]   host_laps    = '0;

  // results owed by the block, oldest first
  res_t awaited_results [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  idle_on        = 1'b1;  // random gaps on both sides
  bit  hold_request   = 1'b0;  // asks the receiver for a long hold-off
  bit  holding        = 1'b0;  // receiver is in that hold-off

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  descriptor_queue_with_overrun_flush #(
    .DEPTH(DEPTH)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_buffer_address      (in_buffer_address),
    .in_data_length         (in_data_length),
    .in_producer_read_index (in_producer_read_index),
    .in_producer_wrap_count (in_producer_wrap_count),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_result_kind        (out_result_kind),
    .out_address            (out_address),
    .out_length             (out_length),
    .out_drained_count      (out_drained_count)
  );

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // how far the producer has run ahead of the host, in ring entries
  function automatic logic [63:0] producer_backlog(logic [PIDX_W-1:0] pidx,
                                                   logic [WRAP_W-1:0] pwrap);
    logic [WRAP_W-1:0] lap_diff;
    logic [63:0]       ahead;
    lap_diff = pwrap - host_laps;
    // same lap: plain index difference, never negative
    if (lap_diff == '0) begin
      if (pidx >= host_pos) return 64'(pidx) - 64'(host_pos);
      return 64'd0;
    end
    // producer a lap count behind the host counts as no backlog
    if (lap_diff[WRAP_W-1]) return 64'd0;
    ahead = (64'(lap_diff) - 64'd1) * 64'(DEPTH) + 64'(DEPTH)
            - 64'(host_pos) + 64'(pidx);
    if (ahead > BACKLOG_CAP) ahead = BACKLOG_CAP;
    return ahead;
  endfunction

  // applies one accepted beat to the mirror and returns the result it owes
  function automatic res_t queue_outcome(item_t b);
    res_t              r;
    logic [PIDX_W-1:0] slot;
    logic [PIDX_W-1:0] prev;
    logic [63:0]       backlog;
    logic [63:0]       room;
    logic [63:0]       excess;
    int unsigned       n;
    r = '0;
    if (b.op == OP_ENQUEUE) begin
      if (mirror_count >= DEPTH) begin
        // full: descriptor is thrown away
        r.kind = KIND_DROPPED;
      end else begin
        slot = mirror_head + PIDX_W'(mirror_count);
        mirror_addr[slot] = b.addr;
        mirror_len[slot]  = b.len;
        mirror_count++;
        r.kind = KIND_ACCEPTED;
      end
    end else if (mirror_count == 0) begin
      // nothing to pop, no backlog check
      r.kind = KIND_EMPTY;
    end else begin
      slot = mirror_head;
      mirror_head = slot + 1'b1;
      mirror_count--;
      room    = 64'(DEPTH) - 64'(mirror_count);
      backlog = producer_backlog(b.pidx, b.pwrap);
      if (backlog > room) begin
        // overrun: flush the excess, drop the popped entry, jump to producer
        excess = backlog - room;
        n = (excess < 64'(mirror_count)) ? excess[31:0] : mirror_count;
        mirror_head  = mirror_head + n[PIDX_W-1:0];
        mirror_count = mirror_count - n;
        r.kind    = KIND_OVERRUN;
        r.drained = n[DRAIN_W-1:0];
        host_pos  = b.pidx;
        host_laps = b.pwrap;
      end else begin
        prev     = host_pos;
        host_pos = host_pos + 1'b1;
        if (host_pos < prev) host_laps = host_laps + 1'b1;
        r.kind = KIND_DELIVER;
        r.addr = mirror_addr[slot];
        r.len  = mirror_len[slot];
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // beat builders, unused fields are random
  // --------------------------------------------------------------------------

  function automatic item_t enqueue_beat(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    item_t b;
    b.op    = OP_ENQUEUE;
    b.addr  = addr;
    b.len   = len;
    b.pidx  = PIDX_W'($urandom);
    b.pwrap = $urandom;
    return b;
  endfunction

  function automatic item_t service_beat(logic [PIDX_W-1:0] pidx, logic [WRAP_W-1:0] pwrap);
    item_t b;
    b.op    = OP_SERVICE;
    b.addr  = $urandom;
    b.len   = LEN_W'($urandom);
    b.pidx  = pidx;
    b.pwrap = pwrap;
    return b;
  endfunction

  // wrap counts mostly near the host's own lap so that deliveries, partial
  // flushes and full flushes all turn up; the rest is fully random
  function automatic item_t random_beat(int unsigned enq_pct);
    logic [WRAP_W-1:0] pwrap;
    int unsigned       pick;
    if ($urandom_range(0, 99) < enq_pct) return enqueue_beat($urandom, LEN_W'($urandom));
    pick = $urandom_range(0, 9);
    if (pick < 6)       pwrap = host_laps;
    else if (pick < 8)  pwrap = host_laps + 1'b1;
    else if (pick == 8) pwrap = host_laps + WRAP_W'($urandom_range(2, 40));
    else                pwrap = $urandom;
    return service_beat(PIDX_W'($urandom), pwrap);
  endfunction

  // --------------------------------------------------------------------------
  // sender: one beat, optional gap in front, prediction on acceptance
  // --------------------------------------------------------------------------

  task automatic send_beat(input item_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_operation           <= b.op;
    in_buffer_address      <= b.addr;
    in_data_length         <= b.len;
    in_producer_read_index <= b.pidx;
    in_producer_wrap_count <= b.pwrap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(queue_outcome(b));
  endtask

  // --------------------------------------------------------------------------
  // receiver: ready bursts, random stalls and the long hold-off on request
  // --------------------------------------------------------------------------

  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holding      = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got kind %0d",
                 $time, out_result_kind);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("result_kind",   want.kind,    out_result_kind);
        compare_field("address",       want.addr,    out_address);
        compare_field("length",        want.len,     out_length);
        compare_field("drained_count", want.drained, out_drained_count);
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("descriptor_queue_with_overrun_flush test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // service straight after reset finds the queue empty
  task automatic test_empty_service();
    send_beat(service_beat('1, '1));
  endtask

  // fill with extreme and random descriptors, then one more that must be dropped
  task automatic test_fill_and_drop();
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       send_beat(enqueue_beat('0, '0));
        1:       send_beat(enqueue_beat('1, '1));
        2:       send_beat(enqueue_beat(32'hAAAA_AAAA, 16'hAAAA));
        3:       send_beat(enqueue_beat(32'h5555_5555, 16'h5555));
        default: send_beat(enqueue_beat($urandom, LEN_W'($urandom)));
      endcase
    end
    send_beat(enqueue_beat($urandom, LEN_W'($urandom)));
  endtask

  // walks the host position through delivery, lap handling and flushes
  task automatic test_delivery_and_overrun();
    send_beat(service_beat('0, '0));               // no backlog, delivered
    send_beat(service_beat('1, 32'h8000_0000));    // producer a lap behind, delivered
    send_beat(service_beat('0, '0));               // same lap, producer index behind
    send_beat(service_beat('1, '0));               // backlog beyond room, partial flush
    send_beat(service_beat('1, host_laps));        // host index wraps, lap count steps
    send_beat(service_beat('0, host_laps + 32'h7FFF_FFFF)); // huge backlog, flush all
    send_beat(service_beat('1, '1));               // empty again
  endtask

  // segments of random traffic with varying enqueue share and idling
  task automatic test_random_mix(input int segments);
    int unsigned enq_pct;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 35;
        1:       enq_pct = 55;
        2:       enq_pct = 75;
        default: enq_pct = 90;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (30) send_beat(random_beat(enq_pct));
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    idle_on = 1'b0;
    in_valid <= 1'b0;
    hold_request = 1'b1;
    wait (holding);
    @(posedge clk);
    repeat (40) send_beat(random_beat(70));
    idle_on = 1'b1;
  endtask

  // last stretch at full rate on both sides
  task automatic test_unpaced_tail();
    idle_on = 1'b0;
    repeat (150) send_beat(random_beat(50));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_service();
    test_fill_and_drop();
    test_delivery_and_overrun();
    test_random_mix(30);
    test_output_hold_off();
    test_unpaced_tail();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("descriptor_queue_with_overrun_flush test passed");
    end else begin
      $display("descriptor_queue_with_overrun_flush test failed");
    end
    $finish;
  end

endmodule

// File: descriptor_queue_with_overrun_flush.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_front.sv
sv/dq_back.sv
sv/descriptor_queue_with_overrun_flush.sv
bench/tb_descriptor_queue_with_overrun_flush.sv
